### hdl/ipas_pkg.sv
// Shared types, opcodes and the page address function for the ISP page access sequencer.
// No dependencies; used by every module of the block.
package ipas_pkg;

    localparam logic [1:0] OP_LOAD_ADDR = 2'd0;
    localparam logic [1:0] OP_PROGRAM   = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;
    localparam logic [1:0] OP_END       = 2'd3;

    localparam logic [1:0] JOB_PROG = 2'd0;
    localparam logic [1:0] JOB_READ = 2'd1;
    localparam logic [1:0] JOB_END  = 2'd2;

    localparam logic [7:0] CMD_LOAD_FLASH_LO  = 8'h40;
    localparam logic [7:0] CMD_LOAD_FLASH_HI  = 8'h48;
    localparam logic [7:0] CMD_WRITE_EEPROM   = 8'hC1;
    localparam logic [7:0] CMD_COMMIT_FLASH   = 8'h4C;
    localparam logic [7:0] CMD_COMMIT_EEPROM  = 8'hC2;
    localparam logic [7:0] CMD_READ_FLASH_LO  = 8'h20;
    localparam logic [7:0] CMD_READ_FLASH_HI  = 8'h28;
    localparam logic [7:0] CMD_READ_EEPROM    = 8'hA0;

    localparam logic [3:0] POLL_LIMIT_FLASH  = 4'd15;
    localparam logic [3:0] POLL_LIMIT_EEPROM = 4'd10;

    localparam logic [8:0] FLASH_PAGE_RESET  = 9'd64;
    localparam logic [5:0] EEPROM_PAGE_RESET = 6'd4;

    localparam logic [0:0] CFG_FLASH_PAGE  = 1'b0;
    localparam logic [0:0] CFG_EEPROM_PAGE = 1'b1;

    localparam logic       FRAME_CMD  = 1'b0;
    localparam logic       FRAME_POLL = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic        flash;
        logic [15:0] addr;
        logic [7:0]  dlow;
        logic [7:0]  dhigh;
        logic        do_commit;
        logic        commit_flash;
        logic [15:0] commit_page;
    } job_t;

    typedef struct packed {
        logic       empty;
        logic       full;
    } q_status_t;

    function automatic logic [15:0] page_of(
        input logic [15:0] a,
        input logic        flash,
        input logic [8:0]  fps,
        input logic [5:0]  eps
    );
        logic [3:0] sh;
        sh = 4'd0;
        if (flash)
        begin
            case (fps)
                9'd32:   sh = 4'd4;
                9'd64:   sh = 4'd5;
                9'd128:  sh = 4'd6;
                9'd256:  sh = 4'd7;
                default: sh = 4'd0;
            endcase
        end
        else
        begin
            case (eps)
                6'd4:    sh = 4'd2;
                6'd8:    sh = 4'd3;
                6'd16:   sh = 4'd4;
                6'd32:   sh = 4'd5;
                default: sh = 4'd0;
            endcase
        end
        return a & (16'hFFFF << sh);
    endfunction

endpackage

### hdl/ipas_front.sv
// Front end: accepts requests, holds address/page state and config, emits frame jobs.
// Depends on ipas_pkg.
module ipas_front
    import ipas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic        is_flash,
    input  logic [15:0] new_address,
    input  logic [7:0]  data_low,
    input  logic [7:0]  data_high,
    input  q_status_t   q_status,
    output logic        push,
    output job_t        push_job
);

    logic [8:0]  flash_page_reg;
    logic [5:0]  eeprom_page_reg;
    logic [15:0] addr_reg, addr_next;
    logic        pending_reg, pending_next;
    logic        pend_flash_reg, pend_flash_next;
    logic        accept;
    logic        sel_flash;
    logic [15:0] addr_inc;
    logic [15:0] page_cur;
    logic [15:0] page_inc;
    logic        want_push;

    assign in_ready  = !q_status.full;
    assign accept    = in_valid && in_ready;
    assign addr_inc  = addr_reg + 16'd1;
    assign sel_flash = (op == OP_END) ? pend_flash_reg : is_flash;
    assign page_cur  = page_of(addr_reg, sel_flash, flash_page_reg, eeprom_page_reg);
    assign page_inc  = page_of(addr_inc, is_flash, flash_page_reg, eeprom_page_reg);
    assign push      = accept && want_push;

    always_comb
    begin
        addr_next       = addr_reg;
        pending_next    = pending_reg;
        pend_flash_next = pend_flash_reg;
        want_push       = 1'b0;
        push_job.mode         = JOB_PROG;
        push_job.flash        = is_flash;
        push_job.addr         = addr_reg;
        push_job.dlow         = data_low;
        push_job.dhigh        = data_high;
        push_job.do_commit    = 1'b0;
        push_job.commit_flash = is_flash;
        push_job.commit_page  = page_cur;
        case (op)
            OP_LOAD_ADDR:
            begin
                addr_next = new_address;
            end
            OP_PROGRAM:
            begin
                want_push          = 1'b1;
                addr_next          = addr_inc;
                push_job.do_commit = (page_cur != page_inc);
                if (page_cur != page_inc)
                begin
                    pending_next = 1'b0;
                end
                else
                begin
                    pending_next    = 1'b1;
                    pend_flash_next = is_flash;
                end
            end
            OP_READ:
            begin
                want_push     = 1'b1;
                push_job.mode = JOB_READ;
                addr_next     = addr_inc;
            end
            OP_END:
            begin
                want_push             = pending_reg;
                push_job.mode         = JOB_END;
                push_job.do_commit    = 1'b1;
                push_job.commit_flash = pend_flash_reg;
                pending_next          = 1'b0;
            end
            default:
            begin
                want_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_page_reg  <= FLASH_PAGE_RESET;
            eeprom_page_reg <= EEPROM_PAGE_RESET;
            addr_reg        <= 16'd0;
            pending_reg     <= 1'b0;
            pend_flash_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index == CFG_FLASH_PAGE)
            begin
                flash_page_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == CFG_EEPROM_PAGE)
            begin
                eeprom_page_reg <= cfg_data[5:0];
            end
            if (accept)
            begin
                addr_reg       <= addr_next;
                pending_reg    <= pending_next;
                pend_flash_reg <= pend_flash_next;
            end
        end
    end

endmodule

### hdl/ipas_queue.sv
// Two-entry job queue between the front end and the frame sequencer.
// Depends on ipas_pkg.
module ipas_queue
    import ipas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head,
    output q_status_t status
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

### hdl/ipas_back.sv
// Back end: steps through the frames of one job and drives the registered output channel.
// Depends on ipas_pkg.
module ipas_back
    import ipas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head,
    input  q_status_t   q_status,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_kind,
    output logic [7:0]  cmd_opcode,
    output logic [7:0]  addr_high,
    output logic [7:0]  addr_low,
    output logic [7:0]  data_byte,
    output logic [3:0]  poll_limit,
    output logic        last
);

    job_t        job_reg;
    logic        job_valid_reg;
    logic [1:0]  step_reg;
    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  opcode_reg;
    logic [15:0] faddr_reg;
    logic [7:0]  data_reg;
    logic [3:0]  limit_reg;
    logic        last_reg;

    logic        load;
    logic [1:0]  n_data;
    logic [1:0]  rel;
    logic [1:0]  last_step;
    logic        is_last;
    logic        f_kind;
    logic [7:0]  f_opcode;
    logic [15:0] f_addr;
    logic [7:0]  f_data;
    logic [3:0]  f_limit;

    assign load    = job_valid_reg && (!out_valid_reg || out_ready);
    assign is_last = (step_reg == last_step);
    assign pop     = !q_status.empty && (!job_valid_reg || (load && is_last));
    assign n_data  = (job_reg.mode == JOB_END) ? 2'd0 : (job_reg.flash ? 2'd2 : 2'd1);
    assign rel     = step_reg - n_data;

    always_comb
    begin
        case (job_reg.mode)
            JOB_PROG: last_step = n_data - 2'd1 + (job_reg.do_commit ? 2'd2 : 2'd0);
            JOB_READ: last_step = n_data;
            default:  last_step = 2'd1;
        endcase
    end

    always_comb
    begin
        f_kind   = FRAME_CMD;
        f_opcode = 8'd0;
        f_addr   = 16'd0;
        f_data   = 8'd0;
        f_limit  = 4'd0;
        if (step_reg < n_data)
        begin
            f_addr = job_reg.addr;
            if (job_reg.mode == JOB_PROG)
            begin
                if (job_reg.flash)
                begin
                    f_opcode = step_reg[0] ? CMD_LOAD_FLASH_HI : CMD_LOAD_FLASH_LO;
                    f_data   = step_reg[0] ? job_reg.dhigh : job_reg.dlow;
                end
                else
                begin
                    f_opcode = CMD_WRITE_EEPROM;
                    f_data   = job_reg.dlow;
                end
            end
            else
            begin
                if (job_reg.flash)
                begin
                    f_opcode = step_reg[0] ? CMD_READ_FLASH_HI : CMD_READ_FLASH_LO;
                end
                else
                begin
                    f_opcode = CMD_READ_EEPROM;
                end
            end
        end
        else if (job_reg.mode != JOB_READ && rel == 2'd0)
        begin
            f_opcode = job_reg.commit_flash ? CMD_COMMIT_FLASH : CMD_COMMIT_EEPROM;
            f_addr   = job_reg.commit_page;
        end
        else
        begin
            f_kind  = FRAME_POLL;
            f_limit = job_reg.commit_flash ? POLL_LIMIT_FLASH : POLL_LIMIT_EEPROM;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (load)
        begin
            kind_reg   <= f_kind;
            opcode_reg <= f_opcode;
            faddr_reg  <= f_addr;
            data_reg   <= f_data;
            limit_reg  <= f_limit;
            last_reg   <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                job_valid_reg <= 1'b1;
                step_reg      <= 2'd0;
            end
            else if (load)
            begin
                step_reg <= step_reg + 2'd1;
                if (is_last)
                begin
                    job_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_kind = kind_reg;
    assign cmd_opcode = opcode_reg;
    assign addr_high  = faddr_reg[15:8];
    assign addr_low   = faddr_reg[7:0];
    assign data_byte  = data_reg;
    assign poll_limit = limit_reg;
    assign last       = last_reg;

endmodule

### hdl/isp_page_access_sequencer_core.sv
// Top level of the ISP page access sequencer: front end, job queue and frame sequencer.
// Depends on ipas_pkg, ipas_front, ipas_queue and ipas_back.
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_wr_en              cfg_index, cfg_data
//  in        in         in_valid / in_ready    op, is_flash, new_address, data_low, data_high
//  out       out        out_valid / out_ready  frame_kind, cmd_opcode, addr_high, addr_low,
//                                              data_byte, poll_limit, last
//
// Requests are taken one per cycle while the two-entry job queue has room.
// Each request yields 0 to 4 frames, one per cycle while out_ready is high, set by the frame sequencer step counter.
// An accepted request's first frame passes through the queue entry, the job register and the output register;
// the next queued job is taken when the last frame of the current one is loaded.
// Output stalls back up through the queue only; reset empties queue and output register.
module isp_page_access_sequencer_core
    import ipas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic        is_flash,
    input  logic [15:0] new_address,
    input  logic [7:0]  data_low,
    input  logic [7:0]  data_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_kind,
    output logic [7:0]  cmd_opcode,
    output logic [7:0]  addr_high,
    output logic [7:0]  addr_low,
    output logic [7:0]  data_byte,
    output logic [3:0]  poll_limit,
    output logic        last
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head;

    ipas_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .is_flash    (is_flash),
        .new_address (new_address),
        .data_low    (data_low),
        .data_high   (data_high),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job)
    );

    ipas_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    ipas_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_kind (frame_kind),
        .cmd_opcode (cmd_opcode),
        .addr_high  (addr_high),
        .addr_low   (addr_low),
        .data_byte  (data_byte),
        .poll_limit (poll_limit),
        .last       (last)
    );

    // busy poll always closes a request
    a_poll_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == FRAME_POLL |-> last)
        else $error("busy poll request not marked last");

    // page commit is always followed by a poll
    a_commit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_kind == FRAME_CMD
        && (cmd_opcode == CMD_COMMIT_FLASH || cmd_opcode == CMD_COMMIT_EEPROM) |-> !last)
        else $error("page commit frame marked last");

    a_poll_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_kind == FRAME_POLL)
            == (poll_limit == POLL_LIMIT_FLASH || poll_limit == POLL_LIMIT_EEPROM))
        else $error("poll limit inconsistent with frame kind");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("job queue popped while empty");

endmodule

### tb/isp_page_access_sequencer_core_test.sv
// Self-checking test for isp_page_access_sequencer_core: directed and random page requests.
// Holds a frame scoreboard with its own model of address, page and commit state.
// Depends on ipas_pkg and the core RTL only.
import ipas_pkg::*;

typedef struct packed {
    logic       kind;
    logic [7:0] opcode;
    logic [7:0] addr_hi;
    logic [7:0] addr_lo;
    logic [7:0] data;
    logic [3:0] limit;
    logic       last;
} frame_t;

class frame_scoreboard;
    frame_t      expected_frames[$];
    frame_t      batch[$];
    int          errors;
    logic [8:0]  flash_page;
    logic [5:0]  eeprom_page;
    logic [15:0] word_addr;
    logic        page_open;
    logic        open_is_flash;

    function new();
        errors = 0;
        flash_page = FLASH_PAGE_RESET;
        eeprom_page = EEPROM_PAGE_RESET;
        word_addr = 16'h0000;
        page_open = 1'b0;
        open_is_flash = 1'b0;
    endfunction

    function void set_register(logic [0:0] idx, logic [8:0] val);
        if (idx == CFG_FLASH_PAGE)
            flash_page = val;
        else
            eeprom_page = val[5:0];
    endfunction

    function logic [15:0] page_base(logic [15:0] a, logic fl);
        int sh;
        sh = 0;
        if (fl)
        begin
            if (flash_page == 9'd32) sh = 4;
            else if (flash_page == 9'd64) sh = 5;
            else if (flash_page == 9'd128) sh = 6;
            else if (flash_page == 9'd256) sh = 7;
        end
        else
        begin
            if (eeprom_page == 6'd4) sh = 2;
            else if (eeprom_page == 6'd8) sh = 3;
            else if (eeprom_page == 6'd16) sh = 4;
            else if (eeprom_page == 6'd32) sh = 5;
        end
        return (a >> sh) << sh;
    endfunction

    function void push_cmd(logic [7:0] code, logic [15:0] a, logic [7:0] d);
        frame_t f;
        f = '0;
        f.kind = FRAME_CMD;
        f.opcode = code;
        f.addr_hi = a[15:8];
        f.addr_lo = a[7:0];
        f.data = d;
        batch.push_back(f);
    endfunction

    function void push_poll(logic fl);
        frame_t f;
        f = '0;
        f.kind = FRAME_POLL;
        f.limit = fl ? POLL_LIMIT_FLASH : POLL_LIMIT_EEPROM;
        batch.push_back(f);
    endfunction

    function void push_commit(logic fl, logic [15:0] page);
        push_cmd(fl ? CMD_COMMIT_FLASH : CMD_COMMIT_EEPROM, page, 8'h00);
        push_poll(fl);
    endfunction

    function void note_request(logic [1:0] rq_op, logic fl, logic [15:0] na,
                               logic [7:0] dl, logic [7:0] dh);
        logic [15:0] start_addr;
        logic [15:0] next_addr;
        batch.delete();
        start_addr = word_addr;
        next_addr = start_addr + 16'd1;
        case (rq_op)
            OP_LOAD_ADDR:
                word_addr = na;
            OP_PROGRAM:
            begin
                if (fl)
                begin
                    push_cmd(CMD_LOAD_FLASH_LO, start_addr, dl);
                    push_cmd(CMD_LOAD_FLASH_HI, start_addr, dh);
                end
                else
                    push_cmd(CMD_WRITE_EEPROM, start_addr, dl);
                word_addr = next_addr;
                if (page_base(start_addr, fl) != page_base(next_addr, fl))
                begin
                    push_commit(fl, page_base(start_addr, fl));
                    page_open = 1'b0;
                end
                else
                begin
                    page_open = 1'b1;
                    open_is_flash = fl;
                end
            end
            OP_READ:
            begin
                if (fl)
                begin
                    push_cmd(CMD_READ_FLASH_LO, start_addr, 8'h00);
                    push_cmd(CMD_READ_FLASH_HI, start_addr, 8'h00);
                end
                else
                    push_cmd(CMD_READ_EEPROM, start_addr, 8'h00);
                push_poll(fl);
                word_addr = next_addr;
            end
            OP_END:
            begin
                if (page_open)
                    push_commit(open_is_flash, page_base(start_addr, open_is_flash));
                page_open = 1'b0;
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_frames.push_back(batch[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    function void check_frame(frame_t got);
        frame_t want;
        if (expected_frames.size() == 0)
        begin
            $error("frame with no request outstanding: %h", got);
            errors++;
            return;
        end
        want = expected_frames.pop_front();
        compare_field("frame_kind", 8'(want.kind), 8'(got.kind));
        compare_field("cmd_opcode", want.opcode, got.opcode);
        compare_field("addr_high", want.addr_hi, got.addr_hi);
        compare_field("addr_low", want.addr_lo, got.addr_lo);
        compare_field("data_byte", want.data, got.data);
        compare_field("poll_limit", 8'(want.limit), 8'(got.limit));
        compare_field("last", 8'(want.last), 8'(got.last));
    endfunction

    function int outstanding();
        return expected_frames.size();
    endfunction
endclass

module isp_page_access_sequencer_core_test;

    localparam int CYCLE_LIMIT = 300000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic        is_flash;
    logic [15:0] new_address;
    logic [7:0]  data_low;
    logic [7:0]  data_high;
    logic        out_valid;
    logic        out_ready;
    logic        frame_kind;
    logic [7:0]  cmd_opcode;
    logic [7:0]  addr_high;
    logic [7:0]  addr_low;
    logic [7:0]  data_byte;
    logic [3:0]  poll_limit;
    logic        last;

    frame_scoreboard sb = new();
    int in_gap_max = 9;
    int out_stall_max = 9;
    int items_sent = 0;
    int cycles = 0;

    logic [8:0] flash_sizes[7] = '{9'd256, 9'd32, 9'd0, 9'd128, 9'd511, 9'd64, 9'd100};
    logic [8:0] eeprom_sizes[7] = '{9'd32, 9'd4, 9'd0, 9'd16, 9'd63, 9'd8, 9'd7};

    isp_page_access_sequencer_core u_top (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        frame_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind = frame_kind;
            got.opcode = cmd_opcode;
            got.addr_hi = addr_high;
            got.addr_lo = addr_low;
            got.data = data_byte;
            got.limit = poll_limit;
            got.last = last;
            sb.check_frame(got);
        end
    end

    // frame sink with random stalls
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    task automatic send(input logic [1:0] rq_op, input logic fl, input logic [15:0] na,
                        input logic [7:0] dl, input logic [7:0] dh);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op = rq_op;
        is_flash = fl;
        new_address = na;
        data_low = dl;
        data_high = dh;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_request(rq_op, fl, na, dl, dh);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [8:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_wr_en = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_register(idx, val);
    endtask

    task automatic run_phase(input int count);
        int target;
        int run_len;
        logic fl;
        logic [15:0] a;
        target = items_sent + count;
        while (items_sent < target)
        begin
            in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            if ($urandom_range(0, 9) < 7)
            begin
                // load, a run of program units, usually an end
                fl = 1'($urandom_range(0, 1));
                a = 16'($urandom);
                if ($urandom_range(0, 1))
                    a[6:0] = 7'h7F - 7'($urandom_range(0, 5));
                if ($urandom_range(0, 15) == 0)
                    a[15:7] = '1;
                send(OP_LOAD_ADDR, 1'($urandom), a, 8'($urandom), 8'($urandom));
                run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70)
                                                      : $urandom_range(1, 10);
                repeat (run_len)
                begin
                    if ($urandom_range(0, 19) == 0)
                        fl = ~fl;
                    send(OP_PROGRAM, fl, 16'($urandom), 8'($urandom), 8'($urandom));
                end
                if ($urandom_range(0, 3) != 0)
                    send(OP_END, 1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            end
            else
                send(2'($urandom_range(0, 3)), 1'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_FLASH_PAGE;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_LOAD_ADDR;
        is_flash = 1'b0;
        new_address = '0;
        data_low = '0;
        data_high = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed, reset page sizes
        send(OP_END, 1'b1, 16'hFFFF, 8'hFF, 8'hFF);
        send(OP_READ, 1'b0, 16'h0000, 8'h00, 8'h00);
        send(OP_READ, 1'b1, 16'h0000, 8'h00, 8'h00);
        send(OP_PROGRAM, 1'b0, 16'h0000, 8'hFF, 8'h00);
        send(OP_PROGRAM, 1'b1, 16'h0000, 8'h00, 8'hFF);
        send(OP_END, 1'b0, 16'h0000, 8'h00, 8'h00);
        send(OP_LOAD_ADDR, 1'b0, 16'h0003, 8'h00, 8'h00);
        send(OP_PROGRAM, 1'b0, 16'h0000, 8'hAA, 8'h55);
        send(OP_LOAD_ADDR, 1'b1, 16'h001F, 8'h00, 8'h00);
        send(OP_PROGRAM, 1'b1, 16'h0000, 8'h55, 8'hAA);
        send(OP_LOAD_ADDR, 1'b1, 16'hFFFF, 8'h00, 8'h00);
        send(OP_PROGRAM, 1'b1, 16'hFFFF, 8'hFF, 8'hFF);
        send(OP_LOAD_ADDR, 1'b0, 16'hFFFF, 8'h00, 8'h00);
        send(OP_READ, 1'b0, 16'h0000, 8'h00, 8'h00);
        send(OP_LOAD_ADDR, 1'b0, 16'hFFFE, 8'h00, 8'h00);
        send(OP_PROGRAM, 1'b0, 16'h0000, 8'h0F, 8'hF0);
        send(OP_LOAD_ADDR, 1'b0, 16'h1234, 8'h00, 8'h00);
        send(OP_END, 1'b1, 16'h0000, 8'h00, 8'h00);
        send(OP_END, 1'b0, 16'h0000, 8'h00, 8'h00);
        send(OP_PROGRAM, 1'b0, 16'hAAAA, 8'h5A, 8'hA5);
        send(OP_PROGRAM, 1'b1, 16'h5555, 8'hC3, 8'h3C);
        send(OP_END, 1'b0, 16'h0000, 8'h00, 8'h00);
        send(OP_LOAD_ADDR, 1'b1, 16'h0000, 8'h00, 8'h00);
        send(OP_READ, 1'b1, 16'h0000, 8'hFF, 8'hFF);
        settle();

        for (int p = 0; p < 7; p++)
        begin
            write_register(CFG_FLASH_PAGE, flash_sizes[p]);
            write_register(CFG_EEPROM_PAGE, eeprom_sizes[p]);
            run_phase(36);
            settle();
        end

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
